// ===== rtl/elm_pkg.sv =====
// shared types, constants and divide helpers for the elevon mixer
package elm_pkg;

    localparam int unsigned RAW_W      = 11;
    localparam int unsigned ANGLE_W    = 8;
    localparam int unsigned PULSE_W    = 12;
    localparam int unsigned IDX_W      = 3;
    localparam int unsigned SERVO_MAG_W = 19;
    localparam int unsigned THR_MAG_W   = 21;
    localparam int unsigned SERVO_Q_W   = 9;
    localparam int unsigned THR_Q_W     = 11;

    localparam int unsigned RC_LOW     = 172;
    localparam int unsigned RC_HIGH    = 1810;
    localparam int unsigned RC_SPAN    = RC_HIGH - RC_LOW;
    localparam int unsigned PULSE_LOW  = 1000;
    localparam int unsigned PULSE_HIGH = 2000;
    localparam int unsigned PULSE_SPAN = PULSE_HIGH - PULSE_LOW;

    // reciprocal of the receiver span, exact for the operand widths below
    localparam int unsigned SERVO_SHIFT = 30;
    localparam int unsigned THR_SHIFT   = 32;
    localparam longint unsigned SERVO_RECIP =
        ((64'd1 << SERVO_SHIFT) + RC_SPAN - 1) / RC_SPAN;
    localparam longint unsigned THR_RECIP =
        ((64'd1 << THR_SHIFT) + RC_SPAN - 1) / RC_SPAN;

    localparam logic [RAW_W-1:0]   ARM_THRESHOLD_RST = 11'd1000;
    localparam logic [ANGLE_W-1:0] MIN_ANGLE_RST     = 8'd20;
    localparam logic [ANGLE_W-1:0] MAX_ANGLE_RST     = 8'd55;

    typedef enum logic [IDX_W-1:0] {
        REG_ARM_THRESHOLD = 3'd0,
        REG_LEFT_MIN      = 3'd1,
        REG_LEFT_MAX      = 3'd2,
        REG_RIGHT_MIN     = 3'd3,
        REG_RIGHT_MAX     = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [RAW_W-1:0]   arm_threshold;
        logic [ANGLE_W-1:0] left_min;
        logic [ANGLE_W-1:0] left_max;
        logic [ANGLE_W-1:0] right_min;
        logic [ANGLE_W-1:0] right_max;
    } t_cfg;

    typedef struct packed {
        logic [RAW_W-1:0] arm;
        logic [RAW_W-1:0] thr;
        logic [RAW_W-1:0] roll;
        logic [RAW_W-1:0] pitch;
        logic             failsafe;
    } t_frame;

    typedef struct packed {
        logic                   neg;
        logic [SERVO_MAG_W-1:0] mag;
    } t_term;

    typedef struct packed {
        t_term roll;
        t_term pitch;
    } t_servo_prod;

    typedef struct packed {
        logic                 run;
        logic                 failsafe;
        logic                 thr_neg;
        logic [THR_MAG_W-1:0] thr_mag;
        t_servo_prod          left;
        t_servo_prod          right;
    } t_front;

    function automatic logic [SERVO_Q_W-1:0] div_servo(input logic [SERVO_MAG_W-1:0] mag);
        logic [SERVO_MAG_W+20-1:0] prod;
        prod = {20'd0, mag} * (SERVO_MAG_W+20)'(SERVO_RECIP);
        return prod[SERVO_MAG_W+20-1:SERVO_SHIFT];
    endfunction

    function automatic logic [THR_Q_W-1:0] div_thr(input logic [THR_MAG_W-1:0] mag);
        logic [THR_MAG_W+22-1:0] prod;
        prod = {22'd0, mag} * (THR_MAG_W+22)'(THR_RECIP);
        return prod[THR_MAG_W+22-1:THR_SHIFT];
    endfunction

endpackage

// ===== rtl/elm_cfg.sv =====
// configuration register file
module elm_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [elm_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [elm_pkg::RAW_W-1:0]  i_cfg_data,
    output elm_pkg::t_cfg              o_cfg
);
    import elm_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ARM_THRESHOLD: n_cfg.arm_threshold = i_cfg_data;
                REG_LEFT_MIN:      n_cfg.left_min  = i_cfg_data[ANGLE_W-1:0];
                REG_LEFT_MAX:      n_cfg.left_max  = i_cfg_data[ANGLE_W-1:0];
                REG_RIGHT_MIN:     n_cfg.right_min = i_cfg_data[ANGLE_W-1:0];
                REG_RIGHT_MAX:     n_cfg.right_max = i_cfg_data[ANGLE_W-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.arm_threshold <= ARM_THRESHOLD_RST;
            r_cfg.left_min      <= MIN_ANGLE_RST;
            r_cfg.left_max      <= MAX_ANGLE_RST;
            r_cfg.right_min     <= MIN_ANGLE_RST;
            r_cfg.right_max     <= MAX_ANGLE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== rtl/elm_front.sv =====
// first stage: arm decision, offsets and span products
module elm_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  elm_pkg::t_frame i_frame,
    input  elm_pkg::t_cfg   i_cfg,
    output logic            o_valid,
    output elm_pkg::t_front o_front
);
    import elm_pkg::*;

    function automatic t_term scaled(input logic signed [RAW_W:0] d,
                                     input logic signed [ANGLE_W:0] span);
        logic [RAW_W-1:0]   d_mag;
        logic [ANGLE_W-1:0] s_mag;
        logic [RAW_W:0]     d_neg_v;
        logic [ANGLE_W:0]   s_neg_v;
        t_term              t;
        d_neg_v = -d;
        s_neg_v = -span;
        d_mag   = d[RAW_W] ? d_neg_v[RAW_W-1:0] : d[RAW_W-1:0];
        s_mag   = span[ANGLE_W] ? s_neg_v[ANGLE_W-1:0] : span[ANGLE_W-1:0];
        t.neg   = d[RAW_W] ^ span[ANGLE_W];
        t.mag   = SERVO_MAG_W'(d_mag) * SERVO_MAG_W'(s_mag);
        return t;
    endfunction

    logic signed [RAW_W:0]   thr_d;
    logic signed [RAW_W:0]   roll_d;
    logic signed [RAW_W:0]   pitch_d;
    logic signed [RAW_W:0]   pitch_rev_d;
    logic signed [RAW_W:0]   thr_neg_v;
    logic [RAW_W-1:0]        thr_mag;
    logic signed [ANGLE_W:0] span_l;
    logic signed [ANGLE_W:0] span_r;
    t_front                  n_front;
    t_front                  r_front;
    logic                    r_valid;

    always_comb begin
        thr_d       = {1'b0, i_frame.thr}   - (RAW_W+1)'(RC_LOW);
        roll_d      = {1'b0, i_frame.roll}  - (RAW_W+1)'(RC_LOW);
        pitch_d     = {1'b0, i_frame.pitch} - (RAW_W+1)'(RC_LOW);
        pitch_rev_d = (RAW_W+1)'(RC_HIGH)   - {1'b0, i_frame.pitch};
        thr_neg_v   = -thr_d;
        thr_mag     = thr_d[RAW_W] ? thr_neg_v[RAW_W-1:0] : thr_d[RAW_W-1:0];
        span_l      = {1'b0, i_cfg.left_max}  - {1'b0, i_cfg.left_min};
        span_r      = {1'b0, i_cfg.right_max} - {1'b0, i_cfg.right_min};

        n_front.run         = (i_frame.arm > i_cfg.arm_threshold) && !i_frame.failsafe;
        n_front.failsafe    = i_frame.failsafe;
        n_front.thr_neg     = thr_d[RAW_W];
        n_front.thr_mag     = THR_MAG_W'(thr_mag) * THR_MAG_W'(PULSE_SPAN);
        n_front.left.roll   = scaled(roll_d, span_l);
        n_front.left.pitch  = scaled(pitch_d, span_l);
        n_front.right.roll  = scaled(roll_d, span_r);
        n_front.right.pitch = scaled(pitch_rev_d, span_r);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_front <= n_front;
    end

    assign o_valid = r_valid;
    assign o_front = r_front;

endmodule

// ===== rtl/elm_back.sv =====
// second stage: span division, mixing, clamping and result register
module elm_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  elm_pkg::t_front               i_front,
    input  elm_pkg::t_cfg                 i_cfg,
    output logic                          o_valid,
    output logic [elm_pkg::PULSE_W-1:0]   o_motor_pulse,
    output logic                          o_motor_disable,
    output logic [elm_pkg::ANGLE_W-1:0]   o_left_angle,
    output logic [elm_pkg::ANGLE_W-1:0]   o_right_angle,
    output logic                          o_link_led
);
    import elm_pkg::*;

    function automatic logic [ANGLE_W-1:0] centre(input logic [ANGLE_W-1:0] mn,
                                                 input logic [ANGLE_W-1:0] mx);
        logic [ANGLE_W:0] s;
        s = {1'b0, mn} + {1'b0, mx};
        return s[ANGLE_W:1];
    endfunction

    function automatic logic [ANGLE_W-1:0] mix(input t_servo_prod sp,
                                              input logic [ANGLE_W-1:0] mn,
                                              input logic [ANGLE_W-1:0] mx);
        logic [SERVO_Q_W-1:0]   qr;
        logic [SERVO_Q_W-1:0]   qp;
        logic signed [PULSE_W-1:0] r;
        logic signed [PULSE_W-1:0] p;
        logic signed [PULSE_W-1:0] v;
        logic signed [PULSE_W-1:0] lo;
        logic signed [PULSE_W-1:0] hi;
        logic signed [PULSE_W-1:0] c;
        qr = div_servo(sp.roll.mag);
        qp = div_servo(sp.pitch.mag);
        lo = {{(PULSE_W-ANGLE_W){1'b0}}, mn};
        hi = {{(PULSE_W-ANGLE_W){1'b0}}, mx};
        c  = {{(PULSE_W-ANGLE_W){1'b0}}, centre(mn, mx)};
        r  = {{(PULSE_W-SERVO_Q_W){1'b0}}, qr};
        p  = {{(PULSE_W-SERVO_Q_W){1'b0}}, qp};
        if (sp.roll.neg) begin
            r = -r;
        end
        if (sp.pitch.neg) begin
            p = -p;
        end
        v = r + lo + p + lo - c;
        if (v < lo) begin
            v = lo;
        end
        if (v > hi) begin
            v = hi;
        end
        return v[ANGLE_W-1:0];
    endfunction

    logic [THR_Q_W-1:0]  thr_q;
    logic                r_valid;
    logic [PULSE_W-1:0]  r_pulse;
    logic                r_disable;
    logic [ANGLE_W-1:0]  r_left;
    logic [ANGLE_W-1:0]  r_right;
    logic                r_led;
    logic [PULSE_W-1:0]  n_pulse;
    logic                n_disable;
    logic [ANGLE_W-1:0]  n_left;
    logic [ANGLE_W-1:0]  n_right;

    always_comb begin
        thr_q = div_thr(i_front.thr_mag);
        if (i_front.run) begin
            n_pulse   = i_front.thr_neg
                      ? PULSE_W'(PULSE_LOW) - {1'b0, thr_q}
                      : PULSE_W'(PULSE_LOW) + {1'b0, thr_q};
            n_disable = 1'b0;
            n_left    = mix(i_front.left, i_cfg.left_min, i_cfg.left_max);
            n_right   = mix(i_front.right, i_cfg.right_min, i_cfg.right_max);
        end else begin
            n_pulse   = PULSE_W'(PULSE_LOW);
            n_disable = 1'b1;
            n_left    = centre(i_cfg.left_min, i_cfg.left_max);
            n_right   = centre(i_cfg.right_min, i_cfg.right_max);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pulse   <= n_pulse;
        r_disable <= n_disable;
        r_left    <= n_left;
        r_right   <= n_right;
        r_led     <= !i_front.failsafe;
    end

    assign o_valid         = r_valid;
    assign o_motor_pulse   = r_pulse;
    assign o_motor_disable = r_disable;
    assign o_left_angle    = r_left;
    assign o_right_angle   = r_right;
    assign o_link_led      = r_led;

endmodule

// ===== rtl/flying_wing_elevon_mixer_unit.sv =====
// top level of the flying wing elevon mixer
//
//  channel   | signals                                  | transfer when
//  ----------+------------------------------------------+------------------------------
//  frame in  | start, busy, i_arm_value .. i_failsafe_  | start high, busy low
//  result    | o_result_valid, o_motor_pulse .. o_link_ | o_result_valid high
//  config    | i_cfg_valid, o_cfg_ready, i_cfg_index/.. | i_cfg_valid and o_cfg_ready
//
// a frame is taken every cycle; busy stays low
// its result reaches the outputs through the input register, the
// product stage, then the divide/mix/clamp stage into the result register
// o_result_valid is a one cycle strobe; the receiver cannot stall
// synchronous active low reset restores the register defaults and clears the pipe
module flying_wing_elevon_mixer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [elm_pkg::RAW_W-1:0]     i_arm_value,
    input  logic [elm_pkg::RAW_W-1:0]     i_throttle_value,
    input  logic [elm_pkg::RAW_W-1:0]     i_roll_value,
    input  logic [elm_pkg::RAW_W-1:0]     i_pitch_value,
    input  logic                          i_failsafe_active,
    output logic                          o_result_valid,
    output logic [elm_pkg::PULSE_W-1:0]   o_motor_pulse,
    output logic                          o_motor_disable,
    output logic [elm_pkg::ANGLE_W-1:0]   o_left_angle,
    output logic [elm_pkg::ANGLE_W-1:0]   o_right_angle,
    output logic                          o_link_led,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [elm_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [elm_pkg::RAW_W-1:0]     i_cfg_data
);
    import elm_pkg::*;

    t_cfg   cfg;
    t_frame r_frame;
    logic   r_in_valid;
    logic   front_valid;
    t_front front;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_frame.arm      <= i_arm_value;
            r_frame.thr      <= i_throttle_value;
            r_frame.roll     <= i_roll_value;
            r_frame.pitch    <= i_pitch_value;
            r_frame.failsafe <= i_failsafe_active;
        end
    end

    elm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    elm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_frame (r_frame),
        .i_cfg   (cfg),
        .o_valid (front_valid),
        .o_front (front)
    );

    elm_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (front_valid),
        .i_front         (front),
        .i_cfg           (cfg),
        .o_valid         (o_result_valid),
        .o_motor_pulse   (o_motor_pulse),
        .o_motor_disable (o_motor_disable),
        .o_left_angle    (o_left_angle),
        .o_right_angle   (o_right_angle),
        .o_link_led      (o_link_led)
    );

endmodule
